@@ hdl/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vsd_pkg.sv @@
package vsd_pkg;

    localparam int CHUNK_EDGE  = 16;
    localparam int PAD_EDGE    = CHUNK_EDGE + 2;
    localparam int PLANE_SIZE  = PAD_EDGE * PAD_EDGE;
    localparam int POS_W       = $clog2(PAD_EDGE);
    localparam int ADDR_W      = $clog2(PLANE_SIZE);
    localparam int VALUE_W     = 8;
    localparam int FIELD_W     = 4;
    localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * FIELD_W + 7) / 8) * 8;

    // Column word: occupancy of one (x, y) in the last two planes.
    localparam int COL_W   = 2;
    localparam int NEW_BIT = 1;   // most recent plane
    localparam int OLD_BIT = 0;   // plane before that

    // Read runs this many positions ahead of the current item.
    localparam int LOOKAHEAD = PAD_EDGE + 1;

    // Column line taps, relative to the current item position t.
    localparam int LINE_LEN = 2 * PAD_EDGE;
    localparam int TAP_XP   = PAD_EDGE - 2;      // t + 1
    localparam int TAP_C    = PAD_EDGE - 1;      // t
    localparam int TAP_XM   = PAD_EDGE;          // t - 1
    localparam int TAP_YM   = 2 * PAD_EDGE - 1;  // t - PAD_EDGE

    typedef struct packed {
        logic [FIELD_W-1:0] box_z;
        logic [FIELD_W-1:0] box_y;
        logic [FIELD_W-1:0] box_x;
    } box_t;

endpackage

@@ hdl/voxel_surface_detect_unit.sv @@
// Surface voxel finder for one padded chunk (edge CHUNK_EDGE + 2) streamed in raster
// order, x fastest, z slowest, one voxel value per item; nonzero means solid. For every
// solid voxel inside the padding with at least one empty face neighbour, the block emits
// its local coordinates (padded coordinate minus one) when its +z neighbour arrives; the
// result is registered in the output stage. One item is taken every cycle: the plane
// history sits in a 324 x 2 column RAM (one bit for each of the last two planes per
// (x, y)), read PAD_EDGE + 1 positions ahead of the input and written back at the
// current position on the same cycle, so the single read port and single write port
// set the rate. Read and write addresses never meet, so no forwarding is needed. There
// is no clearing pass after reset: entries of the RAM are only used once the chunk has
// rewritten them. A two-deep output stage (register plus skid) lets one more result in
// while a result waits; input stalls only when both are full. Position counters restart
// at the chunk origin on reset and wrap after the last voxel.

module voxel_surface_detect_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [vsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] voxel_value

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [vsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // [3:0] box_x, [7:4] box_y,
                                                             // [11:8] box_z, rest zero
);

    localparam int POS_W  = vsd_pkg::POS_W;
    localparam int ADDR_W = vsd_pkg::ADDR_W;

    // ---------------------------------------------------------------- position
    logic [POS_W-1:0]  pos_x_reg, pos_x_next;
    logic [POS_W-1:0]  pos_y_reg, pos_y_next;
    logic [POS_W-1:0]  pos_z_reg, pos_z_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;   // x + PAD_EDGE * y

    logic in_accept;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        addr_next  = addr_reg;
        if (in_accept)
        begin
            if (addr_reg == ADDR_W'(vsd_pkg::PLANE_SIZE - 1))
            begin
                addr_next = '0;
            end
            else
            begin
                addr_next = addr_reg + ADDR_W'(1);
            end

            if (pos_x_reg == POS_W'(vsd_pkg::PAD_EDGE - 1))
            begin
                pos_x_next = '0;
                if (pos_y_reg == POS_W'(vsd_pkg::PAD_EDGE - 1))
                begin
                    pos_y_next = '0;
                    if (pos_z_reg == POS_W'(vsd_pkg::PAD_EDGE - 1))
                    begin
                        pos_z_next = '0;
                    end
                    else
                    begin
                        pos_z_next = pos_z_reg + POS_W'(1);
                    end
                end
                else
                begin
                    pos_y_next = pos_y_reg + POS_W'(1);
                end
            end
            else
            begin
                pos_x_next = pos_x_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            addr_reg  <= addr_next;
        end
    end

    // ---------------------------------------------------------------- column RAM
    // Read address runs LOOKAHEAD ahead, modulo one plane. With the registered read,
    // rdata at the current item is the column of (x, y + 1).
    logic [ADDR_W:0]                 ahead_sum;
    logic [ADDR_W-1:0]               rd_addr;
    logic [vsd_pkg::COL_W-1:0]       rd_col;
    logic [vsd_pkg::COL_W-1:0]       wr_col;
    logic                            here;

    assign ahead_sum = {1'b0, addr_reg} + (ADDR_W + 1)'(vsd_pkg::LOOKAHEAD);

    always_comb
    begin
        if (ahead_sum >= (ADDR_W + 1)'(vsd_pkg::PLANE_SIZE))
        begin
            rd_addr = ADDR_W'(ahead_sum - (ADDR_W + 1)'(vsd_pkg::PLANE_SIZE));
        end
        else
        begin
            rd_addr = ADDR_W'(ahead_sum);
        end
    end

    assign here = |s_axis_tdata[vsd_pkg::VALUE_W-1:0];

    vsd_ram #(
        .DEPTH  (vsd_pkg::PLANE_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (vsd_pkg::COL_W)
    ) u_col_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (addr_reg),
        .wdata (wr_col),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (rd_col)
    );

    // ---------------------------------------------------------------- column line
    // Columns read from the RAM, oldest at the far end; fixed taps give the
    // in-plane neighbours and the center column.
    logic [vsd_pkg::COL_W-1:0] line_reg [vsd_pkg::LINE_LEN];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_reg[0] <= rd_col;
            for (int k = 1; k < vsd_pkg::LINE_LEN; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    // new column word: this plane on top, center's previous plane below
    assign wr_col = {here, line_reg[vsd_pkg::TAP_C][vsd_pkg::NEW_BIT]};

    // ---------------------------------------------------------------- decision
    logic        in_core;
    logic        center;
    logic        open_face;
    logic        hit;
    vsd_pkg::box_t hit_box;

    // z - 1 <= CHUNK_EDGE always holds since z < PAD_EDGE
    assign in_core = (pos_z_reg >= POS_W'(2))
                  && (pos_x_reg >= POS_W'(1)) && (pos_x_reg <= POS_W'(vsd_pkg::CHUNK_EDGE))
                  && (pos_y_reg >= POS_W'(1)) && (pos_y_reg <= POS_W'(vsd_pkg::CHUNK_EDGE));

    assign center    = line_reg[vsd_pkg::TAP_C][vsd_pkg::NEW_BIT];
    assign open_face = !here
                    || !line_reg[vsd_pkg::TAP_XM][vsd_pkg::NEW_BIT]
                    || !line_reg[vsd_pkg::TAP_XP][vsd_pkg::NEW_BIT]
                    || !line_reg[vsd_pkg::TAP_YM][vsd_pkg::NEW_BIT]
                    || !rd_col[vsd_pkg::NEW_BIT]
                    || !line_reg[vsd_pkg::TAP_C][vsd_pkg::OLD_BIT];

    assign hit = in_accept && in_core && center && open_face;

    assign hit_box.box_x = vsd_pkg::FIELD_W'(pos_x_reg - POS_W'(1));
    assign hit_box.box_y = vsd_pkg::FIELD_W'(pos_y_reg - POS_W'(1));
    assign hit_box.box_z = vsd_pkg::FIELD_W'(pos_z_reg - POS_W'(2));

    // ---------------------------------------------------------------- output stage
    logic          out_valid_reg,  out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    vsd_pkg::box_t out_reg,  out_next;
    vsd_pkg::box_t skid_reg, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                // input is held off while skid is full, so no hit here
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = hit_box;
                out_valid_next = hit;
            end
        end
        else if (hit)
        begin
            skid_next       = hit_box;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = vsd_pkg::OUT_TDATA_W'(out_reg);

endmodule

@@ hdl/vsd_ram.sv @@
module vsd_ram #(
    parameter int DEPTH  = 324,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 2
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/vsd_checker.sv @@
`include "assert_macros.svh"

module vsd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [vsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // a new result only follows an accepted item
    `ASSERT_IMPL(a_out_cause, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready), "result without an input item")

    // input back-pressure only when the output side is occupied
    `ASSERT_IMPL(a_ready_full, clk, rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with output empty")

    // pad bits above the three coordinates stay zero
    `ASSERT_IMPL(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[vsd_pkg::OUT_TDATA_W-1:3*vsd_pkg::FIELD_W] == '0, "nonzero pad bits")

endmodule

bind voxel_surface_detect_unit vsd_checker u_vsd_checker (.*);
